FILE: rtl/sfa_pkg.sv
// sfa_pkg: types, constants and fp32 helper functions for the scaled float
// accumulate block. No dependencies.
`timescale 1ns / 1ps

package sfa_pkg;

  localparam int unsigned SigW    = 48;
  localparam int unsigned ExpW    = 11;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned TagMulW = 33;
  localparam int unsigned TagAddW = 1;

  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [31:0] INF_BITS     = 32'h7F80_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
  localparam logic [31:0] SCALE_RESET  = 32'h3F80_0000;

  localparam logic [CfgIdxW-1:0] CFG_SCALE = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_HALF  = CfgIdxW'(1);

  typedef struct packed {
    logic [31:0] acc_in;
    logic [31:0] source_value;
    logic        last_in;
  } sfa_in_t;

  typedef struct packed {
    logic [31:0] acc_out;
    logic        last_out;
  } sfa_out_t;

  // value = sig * 2^exp, or spec_val verbatim when special
  typedef struct packed {
    logic                   special;
    logic [31:0]            spec_val;
    logic                   sign;
    logic signed [ExpW-1:0] exp;
    logic [SigW-1:0]        sig;
  } sfa_rnd_req_t;

  function automatic logic f_is_nan(logic [31:0] x);
    return x[30:0] > INF_BITS[30:0];
  endfunction

  function automatic logic f_is_inf(logic [31:0] x);
    return x[30:0] == INF_BITS[30:0];
  endfunction

  function automatic logic f_is_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic signed [ExpW-1:0] f_unp_exp(logic [31:0] x);
    if (x[30:23] == 8'd0) begin
      return -ExpW'(149);
    end
    return $signed({3'b000, x[30:23]}) - ExpW'(150);
  endfunction

  function automatic logic [23:0] f_unp_sig(logic [31:0] x);
    return {(x[30:23] != 8'd0), x[22:0]};
  endfunction

endpackage

FILE: rtl/sfa_mul.sv
// sfa_mul: fp16 widening, product special cases and the 24x24 significand
// multiply, one register stage. Depends on sfa_pkg.
`timescale 1ns / 1ps

module sfa_mul import sfa_pkg::*; #(
  parameter int unsigned TagW = TagMulW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     scale_i,
  input  logic            half_i,
  input  logic [31:0]     src_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output sfa_rnd_req_t    req_o,
  output logic [TagW-1:0] tag_o
);

  logic [31:0]  src_w;
  logic [3:0]   t;
  logic [23:0]  hfrac;
  logic         sgn;
  sfa_rnd_req_t req_d, req_q;
  logic         valid_q;
  logic [TagW-1:0] tag_q;

  always_comb begin
    t = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (src_i[i]) t = 4'(i);
    end
    hfrac = {14'd0, src_i[9:0]} << (5'd23 - {1'b0, t});
    if (!half_i) begin
      src_w = src_i;
    end else if (src_i[14:10] == 5'h1F) begin
      src_w = {src_i[15], 8'hFF, src_i[9:0], 13'd0};
    end else if (src_i[14:10] == 5'd0) begin
      if (src_i[9:0] == 10'd0) src_w = {src_i[15], 31'd0};
      else src_w = {src_i[15], 8'({4'd0, t}) + 8'd103, hfrac[22:0]};
    end else begin
      src_w = {src_i[15], 3'd0, src_i[14:10], 23'd0} + {1'b0, 8'd112, 23'd0}
              | {9'd0, src_i[9:0], 13'd0};
    end
  end

  always_comb begin
    sgn           = scale_i[31] ^ src_w[31];
    req_d.special = 1'b1;
    req_d.sign    = sgn;
    req_d.exp     = f_unp_exp(scale_i) + f_unp_exp(src_w);
    req_d.sig     = f_unp_sig(scale_i) * f_unp_sig(src_w);
    if (f_is_nan(scale_i)) begin
      req_d.spec_val = scale_i | QUIET_BIT;
    end else if (f_is_nan(src_w)) begin
      req_d.spec_val = src_w | QUIET_BIT;
    end else if (f_is_inf(scale_i) || f_is_inf(src_w)) begin
      if (f_is_zero(scale_i) || f_is_zero(src_w)) req_d.spec_val = QNAN_DEFAULT;
      else req_d.spec_val = {sgn, INF_BITS[30:0]};
    end else if (f_is_zero(scale_i) || f_is_zero(src_w)) begin
      req_d.spec_val = {sgn, 31'd0};
    end else begin
      req_d.special  = 1'b0;
      req_d.spec_val = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_q <= req_d;
      tag_q <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;
  assign tag_o   = tag_q;

endmodule

FILE: rtl/sfa_round.sv
// sfa_round: normalize stage and round-to-nearest-even stage that pack a
// wide significand into fp32 bits. Depends on sfa_pkg.
`timescale 1ns / 1ps

module sfa_round import sfa_pkg::*; #(
  parameter int unsigned TagW = TagMulW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  sfa_rnd_req_t    req_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [31:0]     res_o,
  output logic [TagW-1:0] tag_o
);

  logic [5:0]             lz;
  logic                   n_valid_q, r_valid_q;
  logic                   n_spec_q;
  logic [31:0]            n_sval_q;
  logic                   n_sign_q;
  logic signed [ExpW-1:0] n_be_d, n_be_q;
  logic [SigW-1:0]        n_norm_d, n_norm_q;
  logic [TagW-1:0]        n_tag_q, r_tag_q;
  logic signed [ExpW-1:0] s;
  logic [5:0]             s6;
  logic [SigW-1:0]        shv;
  logic                   lost, g, st, up;
  logic [23:0]            kept;
  logic [7:0]             be_m1;
  logic [31:0]            bits;
  logic [31:0]            r_res_d, r_res_q;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < SigW; i++) begin
      if (req_i.sig[i]) lz = 6'(SigW - 1 - i);
    end
    n_norm_d = req_i.sig << lz;
    n_be_d   = ExpW'(SigW - 1 + 127) - $signed({5'd0, lz}) + req_i.exp;
  end

  always_comb begin
    s     = ExpW'(1) - n_be_q;
    s6    = (s > ExpW'(SigW + 1)) ? 6'(SigW + 1) : s[5:0];
    shv   = n_norm_q >> s6;
    lost  = (shv << s6) != n_norm_q;
    be_m1 = 8'd0;
    if (n_be_q >= ExpW'(1)) begin
      kept  = n_norm_q[47:24];
      g     = n_norm_q[23];
      st    = |n_norm_q[22:0];
      be_m1 = n_be_q[7:0] - 8'd1;
    end else begin
      kept  = shv[47:24];
      g     = shv[23];
      st    = (|shv[22:0]) | lost;
    end
    up   = g & (st | kept[0]);
    bits = {1'b0, be_m1, 23'd0} + {8'd0, kept} + {31'd0, up};
    if (bits >= INF_BITS) bits = INF_BITS;
    if (n_spec_q) begin
      r_res_d = n_sval_q;
    end else if (n_be_q >= ExpW'(255)) begin
      r_res_d = {n_sign_q, INF_BITS[30:0]};
    end else begin
      r_res_d = {n_sign_q, bits[30:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
    end else if (en_i) begin
      n_valid_q <= valid_i;
      r_valid_q <= n_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_spec_q <= req_i.special;
      n_sval_q <= req_i.spec_val;
      n_sign_q <= req_i.sign;
      n_be_q   <= n_be_d;
      n_norm_q <= n_norm_d;
      n_tag_q  <= tag_i;
      r_res_q  <= r_res_d;
      r_tag_q  <= n_tag_q;
    end
  end

  assign valid_o = r_valid_q;
  assign res_o   = r_res_q;
  assign tag_o   = r_tag_q;

endmodule

FILE: rtl/sfa_add.sv
// sfa_add: sum special cases, exponent compare and alignment stage, then the
// significand add or subtract stage. Depends on sfa_pkg.
`timescale 1ns / 1ps

module sfa_add import sfa_pkg::*; #(
  parameter int unsigned TagW = TagAddW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     acc_i,
  input  logic [31:0]     prod_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output sfa_rnd_req_t    req_o,
  output logic [TagW-1:0] tag_o
);

  logic                   a_spec_d, a_spec_q;
  logic [31:0]            a_sval_d, a_sval_q;
  logic                   a_sa_d, a_sa_q, a_sb_d, a_sb_q;
  logic signed [ExpW-1:0] ea, eb, a_e_d, a_e_q;
  logic [ExpW-1:0]        d;
  logic [SigW-1:0]        mw, mraw, a_ma_d, a_ma_q, a_mb_d, a_mb_q;
  logic                   swap;
  logic                   a_valid_q, b_valid_q;
  logic [TagW-1:0]        a_tag_q, b_tag_q;
  sfa_rnd_req_t           b_req_d, b_req_q;

  always_comb begin
    a_spec_d = 1'b1;
    if (f_is_nan(acc_i)) begin
      a_sval_d = acc_i | QUIET_BIT;
    end else if (f_is_nan(prod_i)) begin
      a_sval_d = prod_i | QUIET_BIT;
    end else if (f_is_inf(acc_i)) begin
      if (f_is_inf(prod_i) && (acc_i[31] != prod_i[31])) a_sval_d = QNAN_DEFAULT;
      else a_sval_d = acc_i;
    end else if (f_is_inf(prod_i)) begin
      a_sval_d = prod_i;
    end else if (f_is_zero(acc_i) && f_is_zero(prod_i)) begin
      a_sval_d = {acc_i[31] & prod_i[31], 31'd0};
    end else if (f_is_zero(acc_i)) begin
      a_sval_d = prod_i;
    end else if (f_is_zero(prod_i)) begin
      a_sval_d = acc_i;
    end else begin
      a_spec_d = 1'b0;
      a_sval_d = 32'd0;
    end

    ea     = f_unp_exp(acc_i);
    eb     = f_unp_exp(prod_i);
    swap   = ea < eb;
    a_sa_d = swap ? prod_i[31] : acc_i[31];
    a_sb_d = swap ? acc_i[31] : prod_i[31];
    a_e_d  = swap ? eb : ea;
    a_ma_d = {1'b0, (swap ? f_unp_sig(prod_i) : f_unp_sig(acc_i)), 23'd0};
    mw     = {1'b0, (swap ? f_unp_sig(acc_i) : f_unp_sig(prod_i)), 23'd0};
    d      = ExpW'(swap ? (eb - ea) : (ea - eb));
    mraw   = mw >> d[5:0];
    if (d >= ExpW'(SigW)) begin
      a_mb_d = SigW'(1);
    end else begin
      a_mb_d = mraw | SigW'((mraw << d[5:0]) != mw);
    end
  end

  always_comb begin
    b_req_d.special  = a_spec_q;
    b_req_d.spec_val = a_sval_q;
    b_req_d.exp      = a_e_q - ExpW'(23);
    b_req_d.sign     = a_sa_q;
    if (a_sa_q == a_sb_q) begin
      b_req_d.sig = a_ma_q + a_mb_q;
    end else if (a_ma_q > a_mb_q) begin
      b_req_d.sig = a_ma_q - a_mb_q;
    end else begin
      b_req_d.sig  = a_mb_q - a_ma_q;
      b_req_d.sign = a_sb_q;
    end
    if (!a_spec_q && (a_sa_q != a_sb_q) && (a_ma_q == a_mb_q)) begin
      b_req_d.special  = 1'b1;
      b_req_d.spec_val = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_spec_q <= a_spec_d;
      a_sval_q <= a_sval_d;
      a_sa_q   <= a_sa_d;
      a_sb_q   <= a_sb_d;
      a_e_q    <= a_e_d;
      a_ma_q   <= a_ma_d;
      a_mb_q   <= a_mb_d;
      a_tag_q  <= tag_i;
      b_req_q  <= b_req_d;
      b_tag_q  <= a_tag_q;
    end
  end

  assign valid_o = b_valid_q;
  assign req_o   = b_req_q;
  assign tag_o   = b_tag_q;

endmodule

FILE: rtl/scaled_float_accumulate.sv
// scaled_float_accumulate: top level, acc_out = acc_in + round(scale * source).
// Depends on sfa_pkg, sfa_mul, sfa_round, sfa_add.
`timescale 1ns / 1ps
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_data_i        | in
//  out     | out_valid_o, out_ready_i, out_data_o     | out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,   | in
//          | cfg_data_i                               |
//
// Seven register stages: multiply, normalize, round, align, add, normalize,
// round. One transfer per cycle while results are taken.
// The last round stage is the output register. When it holds a result that
// is not taken, the whole pipe holds and in_ready_o drops.
// Reset clears all valid bits; scale resets to 1.0, source mode to fp32.

module scaled_float_accumulate import sfa_pkg::*; #(
  parameter int unsigned IdxW = CfgIdxW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sfa_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sfa_out_t        out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IdxW-1:0] cfg_index_i,
  input  logic [31:0]     cfg_data_i
);

  logic [31:0]         scale_bits_q;
  logic                half_q;
  logic                en;
  logic                m_valid, r1_valid, a_valid, r2_valid;
  sfa_rnd_req_t        m_req, a_req;
  logic [TagMulW-1:0]  m_tag, r1_tag;
  logic [31:0]         prod;
  logic [TagAddW-1:0]  a_tag, r2_tag;
  logic [31:0]         res;

  assign cfg_ready_o = 1'b1;
  assign en          = !r2_valid || out_ready_i;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_bits_q <= SCALE_RESET;
      half_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        IdxW'(CFG_SCALE): scale_bits_q <= cfg_data_i;
        IdxW'(CFG_HALF):  half_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sfa_mul #(.TagW(TagMulW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .scale_i (scale_bits_q),
    .half_i  (half_q),
    .src_i   (in_data_i.source_value),
    .tag_i   ({in_data_i.acc_in, in_data_i.last_in}),
    .valid_o (m_valid),
    .req_o   (m_req),
    .tag_o   (m_tag)
  );

  sfa_round #(.TagW(TagMulW)) u_rnd_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_valid),
    .req_i   (m_req),
    .tag_i   (m_tag),
    .valid_o (r1_valid),
    .res_o   (prod),
    .tag_o   (r1_tag)
  );

  sfa_add #(.TagW(TagAddW)) u_add (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r1_valid),
    .acc_i   (r1_tag[TagMulW-1:1]),
    .prod_i  (prod),
    .tag_i   (r1_tag[0]),
    .valid_o (a_valid),
    .req_o   (a_req),
    .tag_o   (a_tag)
  );

  sfa_round #(.TagW(TagAddW)) u_rnd_add (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_valid),
    .req_i   (a_req),
    .tag_i   (a_tag),
    .valid_o (r2_valid),
    .res_o   (res),
    .tag_o   (r2_tag)
  );

  assign out_valid_o         = r2_valid;
  assign out_data_o.acc_out  = res;
  assign out_data_o.last_out = r2_tag[0];

endmodule

FILE: rtl/sfa_checker.sv
// sfa_checker: port-level assertions for scaled_float_accumulate, bound to
// the top level. Depends on sfa_pkg.
`timescale 1ns / 1ps

module sfa_checker import sfa_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input sfa_out_t out_data_o,
  input logic     cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  a_nan_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.acc_out[30:23] == 8'hFF) &&
    (out_data_o.acc_out[22:0] != 23'd0) |-> out_data_o.acc_out[22])
    else $error("signaling NaN on output");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind scaled_float_accumulate sfa_checker u_sfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);
